// ----- sv/sobel_3x3_gradient_filter_assert.svh -----
// Assertion macros used by the Sobel filter top level.
`ifndef SOBEL_3X3_GRADIENT_FILTER_ASSERT_SVH
`define SOBEL_3X3_GRADIENT_FILTER_ASSERT_SVH

// Same-cycle implication, checked on every clock out of reset.
`define SGF_ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define SGF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- sv/sgf_pkg.sv -----
// Types and constants of the Sobel 3x3 gradient filter.
package sgf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W     = 8;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int TOTAL_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int RES_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int ROW_W     = TOTAL_W + 1;
  localparam int SUM_W     = PIX_W + 2;
  localparam int GRAD_W    = PIX_W + 3;

  // Register fields and the write port
  localparam int WFIELD_W  = 12;
  localparam int HFIELD_W  = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } sgf_cfg_idx_e;

  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel;
  } sgf_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] row_gradient;
    logic [PIX_W-1:0] column_gradient;
    logic             last_result;
  } sgf_out_t;

  // Per-item control carried from the counter stage to the datapath
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  value;
    logic              up_ok;
    logic              mid_ok;
    logic              col0;
    logic              have;
    logic              top_z;
    logic              bot_z;
    logic              left_z;
    logic              right_z;
    logic              last;
    logic              restart;
  } sgf_tag_t;

endpackage

// ----- sv/sgf_line_store.sv -----
// Two line memories (upper and middle row) with read-modify-write forwarding.
module sgf_line_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [sgf_pkg::ADDR_W-1:0] rd_addr_i,
  input  logic                       wr_en_i,
  input  logic [sgf_pkg::ADDR_W-1:0] wr_addr_i,
  input  logic [sgf_pkg::PIX_W-1:0]  value_i,
  input  logic                       up_ok_i,
  input  logic                       mid_ok_i,
  output logic [sgf_pkg::PIX_W-1:0]  up_o,
  output logic [sgf_pkg::PIX_W-1:0]  mid_o
);
  import sgf_pkg::*;

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [PIX_W-1:0] up_rd_q, mid_rd_q;
  logic [PIX_W-1:0] fwd_up_q, fwd_mid_q;
  logic             fwd_q;
  logic [PIX_W-1:0] up_raw, mid_raw;

  // Middle row moves up, new value becomes the middle row
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= mid_o;
      middle_mem[wr_addr_i] <= value_i;
    end
    if (rd_en_i) begin
      up_rd_q  <= upper_mem[rd_addr_i];
      mid_rd_q <= middle_mem[rd_addr_i];
    end
  end

  // A read issued on the edge that writes the same entry sees old data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_up_q  <= mid_o;
      fwd_mid_q <= value_i;
    end
  end

  assign up_raw  = fwd_q ? fwd_up_q  : up_rd_q;
  assign mid_raw = fwd_q ? fwd_mid_q : mid_rd_q;
  assign up_o    = up_ok_i  ? up_raw  : '0;
  assign mid_o   = mid_ok_i ? mid_raw : '0;

endmodule

// ----- sv/sgf_ctrl.sv -----
// Configuration registers, raster counters and the first pipeline stage.
module sgf_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sgf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sgf_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  sgf_pkg::sgf_in_t             in_data_i,
  input  logic                         take_i,
  output logic                         rd_en_o,
  output logic [sgf_pkg::ADDR_W-1:0]   rd_addr_o,
  output logic                         s1_valid_o,
  output sgf_pkg::sgf_tag_t            s1_tag_o
);
  import sgf_pkg::*;

  logic [WIDTH_W-1:0]  w_q, w_d;
  logic [HEIGHT_W-1:0] h_q, h_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic [ADDR_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [RES_W-1:0]    res_q, res_d;
  logic                s1_v_q, s1_v_d;
  sgf_tag_t            tag_q, tag_d;

  logic [WFIELD_W-1:0] w_raw;
  logic [HFIELD_W-1:0] h_raw;
  logic [WIDTH_W-1:0]  w_new;
  logic [HEIGHT_W-1:0] h_new;
  logic                accept;
  logic                c_nz, past_h;
  logic [ROW_W-1:0]    h_ext;
  logic [WIDTH_W:0]    col_inc;

  // Config: out-of-range sizes clamp to 1..MAX
  always_comb begin
    w_raw = cfg_wdata_i[WFIELD_W-1:0];
    h_raw = cfg_wdata_i[HFIELD_W-1:0];
    if (w_raw == '0) begin
      w_new = WIDTH_W'(1);
    end else if (int'(w_raw) > MAX_WIDTH) begin
      w_new = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_new = WIDTH_W'(w_raw);
    end
    if (h_raw == '0) begin
      h_new = HEIGHT_W'(1);
    end else if (int'(h_raw) > MAX_HEIGHT) begin
      h_new = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_new = HEIGHT_W'(h_raw);
    end
    w_d = w_q;
    h_d = h_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  w_d = w_new;
        CFG_IMAGE_HEIGHT: h_d = h_new;
        default: ;
      endcase
    end
    total_d = TOTAL_W'(w_d) * TOTAL_W'(h_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= WIDTH_W'(WIDTH_RST);
      h_q     <= HEIGHT_W'(HEIGHT_RST);
      total_q <= TOTAL_W'(WIDTH_RST * HEIGHT_RST);
    end else if (cfg_we_i) begin
      w_q     <= w_d;
      h_q     <= h_d;
      total_q <= total_d;
    end
  end

  assign in_stall_o = s1_v_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign rd_en_o    = accept;
  assign rd_addr_o  = col_q;

  always_comb begin
    c_nz   = (col_q != '0);
    h_ext  = ROW_W'(h_q);
    past_h = (row_q >= h_ext);

    tag_d.addr    = col_q;
    tag_d.value   = (in_data_i.kind == KIND_FLUSH || past_h) ? '0 : in_data_i.pixel;
    tag_d.up_ok   = (row_q >= ROW_W'(2));
    tag_d.mid_ok  = (row_q != '0);
    tag_d.col0    = !c_nz;
    tag_d.have    = c_nz ? tag_d.mid_ok : tag_d.up_ok;
    tag_d.top_z   = c_nz ? (row_q == ROW_W'(1)) : (row_q == ROW_W'(2));
    tag_d.bot_z   = c_nz ? past_h : (row_q > h_ext);
    tag_d.left_z  = c_nz ? (col_q == ADDR_W'(1)) : (w_q == WIDTH_W'(1));
    tag_d.right_z = c_nz ? ((WIDTH_W+1)'(col_q) >= (WIDTH_W+1)'(w_q)) : 1'b1;
    tag_d.last    = ((TOTAL_W'(res_q) + TOTAL_W'(1)) >= total_q);
    tag_d.restart = tag_d.have && tag_d.last;

    col_inc = (WIDTH_W+1)'(col_q) + (WIDTH_W+1)'(1);
    col_d   = col_q;
    row_d   = row_q;
    res_d   = res_q;
    if (accept) begin
      if (tag_d.restart) begin
        col_d = '0;
        row_d = '0;
        res_d = '0;
      end else begin
        if (col_inc >= (WIDTH_W+1)'(w_q)) begin
          col_d = '0;
          if (row_q != '1) begin
            row_d = row_q + ROW_W'(1);
          end
        end else begin
          col_d = ADDR_W'(col_inc);
        end
        if (tag_d.have) begin
          res_d = res_q + RES_W'(1);
        end
      end
    end

    if (accept) begin
      s1_v_d = 1'b1;
    end else if (take_i) begin
      s1_v_d = 1'b0;
    end else begin
      s1_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      res_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      res_q  <= res_d;
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q <= tag_d;
    end
  end

  assign s1_valid_o = s1_v_q;
  assign s1_tag_o   = tag_q;

endmodule

// ----- sv/sgf_kernel.sv -----
// 3x3 window, Sobel sums, clamp and output register.
module sgf_kernel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s1_valid_i,
  input  sgf_pkg::sgf_tag_t         s1_tag_i,
  input  logic [sgf_pkg::PIX_W-1:0] up_i,
  input  logic [sgf_pkg::PIX_W-1:0] mid_i,
  output logic                      take_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output sgf_pkg::sgf_out_t         out_data_o
);
  import sgf_pkg::*;

  // win_q[row][0] is the older column, win_q[row][1] the newer one
  logic [PIX_W-1:0] win_q [3][2];
  logic [PIX_W-1:0] nc [3];
  logic [PIX_W-1:0] t [3][3];

  logic [SUM_W-1:0]         top_s, bot_s, lft_s, rgt_s;
  logic signed [GRAD_W-1:0] rg_d, cg_d, rg_q, cg_q;
  logic                     s2_v_q, s2_last_q;
  logic                     out_v_q;
  sgf_out_t                 out_q, out_d;
  logic                     out_free, s2_free, s1_adv;

  assign out_free = !out_v_q || !out_stall_i;
  assign s2_free  = !s2_v_q || out_free;
  assign s1_adv   = s1_valid_i && s2_free;
  assign take_o   = s2_free;

  always_comb begin
    nc[0] = up_i;
    nc[1] = mid_i;
    nc[2] = s1_tag_i.value;
    for (int i = 0; i < 3; i++) begin
      t[i][0] = win_q[i][0];
      t[i][1] = win_q[i][1];
      t[i][2] = s1_tag_i.col0 ? '0 : nc[i];
    end
    if (s1_tag_i.top_z) begin
      for (int j = 0; j < 3; j++) t[0][j] = '0;
    end
    if (s1_tag_i.bot_z) begin
      for (int j = 0; j < 3; j++) t[2][j] = '0;
    end
    if (s1_tag_i.left_z) begin
      for (int i = 0; i < 3; i++) t[i][0] = '0;
    end
    if (s1_tag_i.right_z) begin
      for (int i = 0; i < 3; i++) t[i][2] = '0;
    end
    bot_s = SUM_W'(t[2][0]) + (SUM_W'(t[2][1]) << 1) + SUM_W'(t[2][2]);
    top_s = SUM_W'(t[0][0]) + (SUM_W'(t[0][1]) << 1) + SUM_W'(t[0][2]);
    rgt_s = SUM_W'(t[0][2]) + (SUM_W'(t[1][2]) << 1) + SUM_W'(t[2][2]);
    lft_s = SUM_W'(t[0][0]) + (SUM_W'(t[1][0]) << 1) + SUM_W'(t[2][0]);
    rg_d  = $signed({1'b0, bot_s}) - $signed({1'b0, top_s});
    cg_d  = $signed({1'b0, rgt_s}) - $signed({1'b0, lft_s});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= '0;
        win_q[i][1] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= s1_tag_i.restart ? '0 : win_q[i][1];
        win_q[i][1] <= s1_tag_i.restart ? '0 : nc[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rg_q      <= rg_d;
      cg_q      <= cg_d;
      s2_last_q <= s1_tag_i.last;
    end
  end

  // Clamp to 0..255
  always_comb begin
    if (rg_q[GRAD_W-1]) begin
      out_d.row_gradient = '0;
    end else if (|rg_q[GRAD_W-2:PIX_W]) begin
      out_d.row_gradient = '1;
    end else begin
      out_d.row_gradient = rg_q[PIX_W-1:0];
    end
    if (cg_q[GRAD_W-1]) begin
      out_d.column_gradient = '0;
    end else if (|cg_q[GRAD_W-2:PIX_W]) begin
      out_d.column_gradient = '1;
    end else begin
      out_d.column_gradient = cg_q[PIX_W-1:0];
    end
    out_d.last_result = s2_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_v_q <= s1_adv && s1_tag_i.have;
      end
      if (out_free) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s2_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/sobel_3x3_gradient_filter.sv -----
// Top level of the 3x3 Sobel gradient filter.
//
//   channel | valid / stall          | payload
//   --------+------------------------+--------------------------------------
//   input   | in_valid_i, in_stall_o | in_data_i  (kind, pixel)
//   output  | out_valid_o, out_stall_i | out_data_o (row/column gradient, last)
//   config  | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle while in_stall_o is low; the line memories are
// read on acceptance and written back when the transaction leaves stage
// one, with forwarding when the next read hits the same entry on that edge.
// A transaction that completes a result is registered in stage one, then in
// stage two, then in the output register that drives out_data_o.
// Reset clears counters, window and valids; first-row reads are masked to zero.
// Output stalls fill the pipeline bubbles first, then reach in_stall_o.
`include "sobel_3x3_gradient_filter_assert.svh"

module sobel_3x3_gradient_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sgf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sgf_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sgf_pkg::sgf_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sgf_pkg::sgf_out_t             out_data_o
);
  import sgf_pkg::*;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              s1_valid;
  sgf_tag_t          s1_tag;
  logic              take;
  logic [PIX_W-1:0]  up, mid;

  sgf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .take_i      (take),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .s1_valid_o  (s1_valid),
    .s1_tag_o    (s1_tag)
  );

  sgf_line_store u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (s1_valid && take),
    .wr_addr_i (s1_tag.addr),
    .value_i   (s1_tag.value),
    .up_ok_i   (s1_tag.up_ok),
    .mid_ok_i  (s1_tag.mid_ok),
    .up_o      (up),
    .mid_o     (mid)
  );

  sgf_kernel u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_tag_i    (s1_tag),
    .up_i        (up),
    .mid_i       (mid),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A new transaction may only enter when the held item moves on
  `SGF_ASSERT_IMPLIES(a_accept_frees_s1, rd_en, !s1_valid || take, "accept over held item")
  // Accepted transaction occupies the first stage on the next cycle
  `SGF_ASSERT_NEXT(a_accept_fills_s1, rd_en, s1_valid, "accepted item lost")
  // A blocked first stage keeps its item and its control unchanged
  `SGF_ASSERT_NEXT(a_s1_hold, s1_valid && !take, s1_valid && $stable(s1_tag), "s1 item changed")

endmodule
